[rtl/lav_pkg.sv]
// Package for the look-at view matrix block: fixed-point widths, pipeline
// latency constants, sideband types and a small helper function.
// No dependencies.
package lav_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CW        = FRAC_BITS + 2;
	localparam int QW        = FRAC_BITS + 2;
	localparam int MW        = FRAC_BITS + 33;
	localparam int VW        = MW + 1;
	localparam int NG        = (MW + 7) / 8;
	localparam int LW        = NG * 8;
	localparam int PW        = $clog2(LW);
	localparam int NUMW      = 31 + FRAC_BITS;
	localparam int NORM_LAT  = 41 + QW;
	localparam int UW        = CW + 1;
	localparam int PRW       = UW + 32;
	localparam int DW        = PRW + 2;

	localparam logic [1:0] ROW_R = 2'd0;
	localparam logic [1:0] ROW_U = 2'd1;
	localparam logic [1:0] ROW_F = 2'd2;

	typedef struct packed {
		logic [2:0][31:0] eye;
		logic [2:0][31:0] up;
	} sb1_t;

	typedef struct packed {
		logic [2:0][31:0]   eye;
		logic [2:0][CW-1:0] f;
		logic               zero;
	} sb2_t;

	function automatic logic [2:0] lod8(input logic [7:0] b);
		logic [2:0] p;
		p = '0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				p = 3'(i);
			end
		end
		return p;
	endfunction

endpackage

[rtl/lav_norm.sv]
// Pipelined fixed-point normalizer for a three-component vector: magnitude,
// common scaling, sum of squares, bit-serial square root and division stages.
// Depends on lav_pkg.
module lav_norm (
	input  logic                          clk,
	input  logic                          en,
	input  logic [2:0][lav_pkg::VW-1:0]   v,
	output logic [2:0][lav_pkg::CW-1:0]   q,
	output logic                          zero
);
	import lav_pkg::*;

	logic [2:0][MW-1:0] mag_s1, mag_s2, mag_s3, mag_s4;
	logic [2:0]         neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;
	logic [MW-1:0]      max_s2;
	logic [MW-1:0]      mx;
	logic [NG-1:0]      nz_s3;
	logic [NG-1:0][2:0] pos_s3;
	logic [PW-1:0]      msb_s4, msb;
	logic               zero_s4, zero_s5, zero_s6, zr;
	logic [LW-1:0]      mx_ext;
	logic [2:0][29:0]   a_s5, a_s6;
	logic [2:0][MW-1:0] sh;
	logic [2:0][59:0]   sq_s6;

	logic [62:0]        rn_s   [33];
	logic [62:0]        rr_s   [33];
	logic [2:0][29:0]   ra_s   [33];
	logic [2:0]         rneg_s [33];
	logic               rz_s   [33];

	logic [2:0][NUMW-1:0] num;
	logic [30:0]          len;
	logic [2:0][31:0]     dr_s   [QW+1];
	logic [2:0][QW-1:0]   dn_s   [QW+1];
	logic [2:0][QW-1:0]   dq_s   [QW+1];
	logic [30:0]          dl_s   [QW+1];
	logic [2:0]           dneg_s [QW+1];
	logic                 dz_s   [QW+1];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s1[i] <= v[i][VW-1];
				mag_s1[i] <= v[i][VW-1] ? MW'(-v[i]) : MW'(v[i]);
			end
		end
	end

	always_comb begin
		mx = mag_s1[0];
		if (mag_s1[1] > mx) begin
			mx = mag_s1[1];
		end
		if (mag_s1[2] > mx) begin
			mx = mag_s1[2];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			max_s2 <= mx;
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
		end
	end

	assign mx_ext = LW'(max_s2);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < NG; g++) begin
				nz_s3[g]  <= |mx_ext[g*8 +: 8];
				pos_s3[g] <= lod8(mx_ext[g*8 +: 8]);
			end
			mag_s3 <= mag_s2;
			neg_s3 <= neg_s2;
		end
	end

	always_comb begin
		msb = '0;
		zr  = 1'b1;
		for (int g = 0; g < NG; g++) begin
			if (nz_s3[g]) begin
				msb = PW'(g * 8) + PW'(pos_s3[g]);
				zr  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			msb_s4  <= msb;
			zero_s4 <= zr;
			mag_s4  <= mag_s3;
			neg_s4  <= neg_s3;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (msb_s4 >= PW'(29)) begin
				sh[i] = mag_s4[i] >> (msb_s4 - PW'(29));
			end else begin
				sh[i] = mag_s4[i] << (PW'(29) - msb_s4);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				a_s5[i] <= sh[i][29:0];
			end
			neg_s5  <= neg_s4;
			zero_s5 <= zero_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= a_s5[i] * a_s5[i];
			end
			a_s6    <= a_s5;
			neg_s6  <= neg_s5;
			zero_s6 <= zero_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rn_s[0]   <= 63'(sq_s6[0]) + 63'(sq_s6[1]) + 63'(sq_s6[2]);
			rr_s[0]   <= '0;
			ra_s[0]   <= a_s6;
			rneg_s[0] <= neg_s6;
			rz_s[0]   <= zero_s6;
		end
	end

	for (genvar k = 0; k < 32; k++) begin : g_sqrt
		localparam logic [62:0] BIT = 63'(1) << (62 - 2 * k);
		logic [62:0] trial;
		assign trial = rr_s[k] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rn_s[k] >= trial) begin
					rn_s[k+1] <= rn_s[k] - trial;
					rr_s[k+1] <= (rr_s[k] >> 1) + BIT;
				end else begin
					rn_s[k+1] <= rn_s[k];
					rr_s[k+1] <= rr_s[k] >> 1;
				end
				ra_s[k+1]   <= ra_s[k];
				rneg_s[k+1] <= rneg_s[k];
				rz_s[k+1]   <= rz_s[k];
			end
		end
	end

	assign len = rr_s[32][30:0];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i] = (NUMW'(ra_s[32][i]) << FRAC_BITS) + NUMW'(len >> 1);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dr_s[0][i] <= 32'(num[i][NUMW-1:QW]);
				dn_s[0][i] <= num[i][QW-1:0];
			end
			dq_s[0]   <= '0;
			dl_s[0]   <= len;
			dneg_s[0] <= rneg_s[32];
			dz_s[0]   <= rz_s[32];
		end
	end

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [2:0][32:0] t;
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				t[i] = {dr_s[j][i], dn_s[j][i][QW-1-j]};
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (t[i] >= 33'(dl_s[j])) begin
						dr_s[j+1][i] <= 32'(t[i] - 33'(dl_s[j]));
						dq_s[j+1][i] <= {dq_s[j][i][QW-2:0], 1'b1};
					end else begin
						dr_s[j+1][i] <= t[i][31:0];
						dq_s[j+1][i] <= {dq_s[j][i][QW-2:0], 1'b0};
					end
				end
				dn_s[j+1]   <= dn_s[j];
				dl_s[j+1]   <= dl_s[j];
				dneg_s[j+1] <= dneg_s[j];
				dz_s[j+1]   <= dz_s[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (dz_s[QW]) begin
					q[i] <= '0;
				end else if (dneg_s[QW][i]) begin
					q[i] <= CW'(-dq_s[QW][i]);
				end else begin
					q[i] <= CW'(dq_s[QW][i]);
				end
			end
			zero <= dz_s[QW];
		end
	end

endmodule

[rtl/look_at_view_matrix.sv]
// Look-at view matrix: from eye, target and up vectors in signed Q16.16 it
// streams the three upper rows of the camera matrix. Depends on lav_pkg, lav_norm.
//
// Usage: one input word on s_tdata carries eye_x, eye_y, eye_z, center_x,
// center_y, center_z, up_x, up_y, up_z (32 bits each, eye_x lowest). For every
// accepted word the block sends three output words in the order right, up,
// forward. m_tdata holds row_index, col0, col1, col2 and col3 from the lowest
// bit; m_tlast marks the forward row and m_tuser is the degenerate flag, set
// on all three rows when the forward or right vector had zero length.
// The right row passes the input register, the forward normalizer, the cross
// product, the right normalizer, the up and dot stages and the output register;
// the up and forward rows follow it. The output register sends all three words
// of one matrix before it loads the next; the pipeline takes a word in every cycle
// while s_tready is high. Reset clears all valid bits and full_q: no word is pending.
// When the receiver stalls, the output word holds and the pipeline advances
// until its last stage holds a finished matrix, then s_tready drops.
module look_at_view_matrix (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [287:0] s_tdata,   // eye_x..z, center_x..z, up_x..z
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [135:0] m_tdata,   // row_index, col0, col1, col2, col3, zero pad
	output logic         m_tlast,   // last_row
	output logic         m_tuser    // degenerate
);
	import lav_pkg::*;

	logic adv;

	logic                 v_s1;
	logic [2:0][31:0]     eye_s1, up_s1;
	logic [2:0][VW-1:0]   d_s1;

	logic [2:0][CW-1:0]   f_n1;
	logic                 zero_n1;
	logic [NORM_LAT-1:0]  vd1_s;
	sb1_t                 sb1_s [NORM_LAT];

	logic                 v_s2, v_s3;
	logic [5:0][CW+31:0]  p_s2;
	sb2_t                 sb_s2, sb_s3;
	logic [2:0][VW-1:0]   c_s3;

	logic [2:0][CW-1:0]   r_n2;
	logic                 zero_n2;
	logic [NORM_LAT-1:0]  vd2_s;
	sb2_t                 sb2_s [NORM_LAT];

	logic                 v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic                 deg_s4, deg_s5, deg_s6, deg_s7, deg_s8, deg_s9, deg_s10;
	logic [2:0][31:0]     eye_s4, eye_s5, eye_s6;
	logic [2:0][CW-1:0]   r_s4, f_s4, r_s5, f_s5, r_s6, f_s6;
	logic [5:0][2*CW-1:0] p_s4;
	logic [2:0][2*CW:0]   ud_s5;
	logic [2:0][2*CW:0]   umag;
	logic [2:0][2*CW:0]   urnd;
	logic [2:0][UW-1:0]   u_s6;
	logic [2:0][2:0][UW-1:0] w;
	logic [2:0][2:0][PRW-1:0] pr_s7;
	logic [2:0][2:0][31:0] col_s7, col_s8, col_s9, col_s10;
	logic [2:0][DW-1:0]   dot_s8;
	logic [2:0][DW-1:0]   dmag;
	logic [2:0][DW-1:0]   rm_s9;
	logic [2:0]           neg_s9;
	logic [2:0][31:0]     t_s10;

	logic                 full_q;
	logic [1:0]           row_q;
	logic [2:0][3:0][31:0] cols_q;
	logic                 deg_q;

	assign adv      = !(v_s10 && full_q && !(m_tready && row_q == ROW_F));
	assign s_tready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				eye_s1[i] <= s_tdata[i*32 +: 32];
				up_s1[i]  <= s_tdata[(6+i)*32 +: 32];
				d_s1[i]   <= VW'($signed({s_tdata[(3+i)*32+31], s_tdata[(3+i)*32 +: 32]})
					- $signed({s_tdata[i*32+31], s_tdata[i*32 +: 32]}));
			end
		end
	end

	lav_norm u_norm_f (
		.clk  (clk),
		.en   (adv),
		.v    (d_s1),
		.q    (f_n1),
		.zero (zero_n1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd1_s <= '0;
		end else if (adv) begin
			vd1_s <= {vd1_s[NORM_LAT-2:0], v_s1};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb1_s[0] <= '{eye: eye_s1, up: up_s1};
			for (int k = 1; k < NORM_LAT; k++) begin
				sb1_s[k] <= sb1_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s2 <= vd1_s[NORM_LAT-1];
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2[0] <= $signed(f_n1[1]) * $signed(sb1_s[NORM_LAT-1].up[2]);
			p_s2[1] <= $signed(f_n1[2]) * $signed(sb1_s[NORM_LAT-1].up[1]);
			p_s2[2] <= $signed(f_n1[2]) * $signed(sb1_s[NORM_LAT-1].up[0]);
			p_s2[3] <= $signed(f_n1[0]) * $signed(sb1_s[NORM_LAT-1].up[2]);
			p_s2[4] <= $signed(f_n1[0]) * $signed(sb1_s[NORM_LAT-1].up[1]);
			p_s2[5] <= $signed(f_n1[1]) * $signed(sb1_s[NORM_LAT-1].up[0]);
			sb_s2   <= '{eye: sb1_s[NORM_LAT-1].eye, f: f_n1, zero: zero_n1};
			for (int i = 0; i < 3; i++) begin
				c_s3[i] <= $signed(p_s2[2*i]) - $signed(p_s2[2*i+1]);
			end
			sb_s3 <= sb_s2;
		end
	end

	lav_norm u_norm_r (
		.clk  (clk),
		.en   (adv),
		.v    (c_s3),
		.q    (r_n2),
		.zero (zero_n2)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vd2_s <= '0;
		end else if (adv) begin
			vd2_s <= {vd2_s[NORM_LAT-2:0], v_s3};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sb2_s[0] <= sb_s3;
			for (int k = 1; k < NORM_LAT; k++) begin
				sb2_s[k] <= sb2_s[k-1];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
			v_s8  <= 1'b0;
			v_s9  <= 1'b0;
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s4  <= vd2_s[NORM_LAT-1];
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s4[0] <= $signed(r_n2[1]) * $signed(sb2_s[NORM_LAT-1].f[2]);
			p_s4[1] <= $signed(r_n2[2]) * $signed(sb2_s[NORM_LAT-1].f[1]);
			p_s4[2] <= $signed(r_n2[2]) * $signed(sb2_s[NORM_LAT-1].f[0]);
			p_s4[3] <= $signed(r_n2[0]) * $signed(sb2_s[NORM_LAT-1].f[2]);
			p_s4[4] <= $signed(r_n2[0]) * $signed(sb2_s[NORM_LAT-1].f[1]);
			p_s4[5] <= $signed(r_n2[1]) * $signed(sb2_s[NORM_LAT-1].f[0]);
			r_s4    <= r_n2;
			f_s4    <= sb2_s[NORM_LAT-1].f;
			eye_s4  <= sb2_s[NORM_LAT-1].eye;
			deg_s4  <= sb2_s[NORM_LAT-1].zero | zero_n2;

			for (int i = 0; i < 3; i++) begin
				ud_s5[i] <= $signed(p_s4[2*i]) - $signed(p_s4[2*i+1]);
			end
			r_s5   <= r_s4;
			f_s5   <= f_s4;
			eye_s5 <= eye_s4;
			deg_s5 <= deg_s4;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			umag[i] = ud_s5[i][2*CW] ? -ud_s5[i] : ud_s5[i];
			urnd[i] = (umag[i] + (2*CW+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				u_s6[i] <= ud_s5[i][2*CW] ? UW'(-urnd[i]) : UW'(urnd[i]);
			end
			r_s6   <= r_s5;
			f_s6   <= f_s5;
			eye_s6 <= eye_s5;
			deg_s6 <= deg_s5;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			w[ROW_R][i] = UW'($signed(r_s6[i]));
			w[ROW_U][i] = u_s6[i];
			w[ROW_F][i] = UW'($signed(f_s6[i]));
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					pr_s7[k][i]  <= $signed(w[k][i]) * $signed(eye_s6[i]);
					col_s7[k][i] <= 32'($signed(w[k][i]));
				end
			end
			deg_s7 <= deg_s6;

			for (int k = 0; k < 3; k++) begin
				dot_s8[k] <= $signed(pr_s7[k][0]) + $signed(pr_s7[k][1])
					+ $signed(pr_s7[k][2]);
			end
			col_s8 <= col_s7;
			deg_s8 <= deg_s7;
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			dmag[k] = dot_s8[k][DW-1] ? -dot_s8[k] : dot_s8[k];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				rm_s9[k]  <= (dmag[k] + DW'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
				neg_s9[k] <= dot_s8[k][DW-1];
			end
			col_s9 <= col_s8;
			deg_s9 <= deg_s8;

			for (int k = 0; k < 3; k++) begin
				if (neg_s9[k]) begin
					t_s10[k] <= (rm_s9[k] > DW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF
						: rm_s9[k][31:0];
				end else begin
					t_s10[k] <= (rm_s9[k] > DW'(33'h0_8000_0000)) ? 32'h8000_0000
						: 32'(32'd0 - rm_s9[k][31:0]);
				end
			end
			col_s10 <= col_s9;
			deg_s10 <= deg_s9;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			row_q  <= ROW_R;
		end else if (adv && v_s10) begin
			full_q <= 1'b1;
			row_q  <= ROW_R;
		end else if (full_q && m_tready) begin
			if (row_q == ROW_F) begin
				full_q <= 1'b0;
				row_q  <= ROW_R;
			end else begin
				row_q <= row_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && v_s10) begin
			for (int k = 0; k < 3; k++) begin
				cols_q[k][0] <= col_s10[k][0];
				cols_q[k][1] <= col_s10[k][1];
				cols_q[k][2] <= col_s10[k][2];
				cols_q[k][3] <= t_s10[k];
			end
			deg_q <= deg_s10;
		end
	end

	assign m_tvalid = full_q;
	assign m_tdata  = {6'd0, cols_q[row_q][3], cols_q[row_q][2], cols_q[row_q][1],
		cols_q[row_q][0], row_q};
	assign m_tlast  = (row_q == ROW_F);
	assign m_tuser  = deg_q;

`ifndef SYNTHESIS
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled while the output register is empty");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[1:0] == ROW_R || m_tdata[1:0] == ROW_U
			|| m_tdata[1:0] == ROW_F))
		else $error("row index out of range");

	a_first_row: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> m_tdata[1:0] == ROW_R)
		else $error("matrix did not start with the right row");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast && !v_s10) |=> !m_tvalid)
		else $error("output stayed valid after the last row was taken");
`endif

endmodule

[tb/tb_look_at_view_matrix.sv]
`timescale 1ns / 1ps
// Testbench for look_at_view_matrix: random and directed camera setups are
// checked row by row against a fixed-point predictor held here.
// Depends on lav_pkg and look_at_view_matrix.
module tb_look_at_view_matrix;
	import lav_pkg::*;

	typedef struct {
		logic [1:0]  row;
		logic [31:0] c0, c1, c2, c3;
		logic        last;
		logic        degen;
	} row_word_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [287:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	logic [135:0] m_tdata;
	logic         m_tlast;
	logic         m_tuser;

	logic [287:0] pending_words[$];
	row_word_t    expected_rows[$];
	int           errors;
	int           rows_seen;
	int           idle_cycles;
	int           send_gap;
	int           recv_gap;
	bit           stimulus_done;
	bit           hold_send;
	int           degen_seen;

	look_at_view_matrix u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

	function automatic longint unsigned abs64(longint v);
		return v < 0 ? longint'(0) - v : v;
	endfunction

	function automatic longint clamp32(longint v);
		if (v > 64'sh7FFFFFFF) return 64'sh7FFFFFFF;
		if (v < -64'sh80000000) return -64'sh80000000;
		return v;
	endfunction

	function automatic longint round_q(longint v);
		longint unsigned m;
		m = (abs64(v) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return v < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic bit unit_vec(input longint v[3], output longint o[3]);
		longint unsigned a[3], m, s, len, q;
		m = 0;
		for (int i = 0; i < 3; i++) begin
			a[i] = abs64(v[i]);
			if (a[i] > m) m = a[i];
			o[i] = 0;
		end
		if (m == 0) return 0;
		while (m >= (64'd1 << 30)) begin
			m = m >> 1;
			for (int i = 0; i < 3; i++) a[i] = a[i] >> 1;
		end
		while (m < (64'd1 << 29)) begin
			m = m << 1;
			for (int i = 0; i < 3; i++) a[i] = a[i] << 1;
		end
		s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
		len = int_sqrt(s);
		for (int i = 0; i < 3; i++) begin
			q = ((a[i] << FRAC_BITS) + (len >> 1)) / len;
			o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
		end
		return 1;
	endfunction

	task automatic predict_view_rows(input logic [287:0] w);
		longint eye[3], up[3], d[3], f[3], c[3], r[3], u[3], rw[3], dot;
		bit ok_f, ok_r;
		row_word_t e;
		for (int i = 0; i < 3; i++) begin
			eye[i] = longint'($signed(w[32*i +: 32]));
			d[i] = longint'($signed(w[32*(i+3) +: 32])) - eye[i];
			up[i] = longint'($signed(w[32*(i+6) +: 32]));
		end
		ok_f = unit_vec(d, f);
		c[0] = f[1] * up[2] - f[2] * up[1];
		c[1] = f[2] * up[0] - f[0] * up[2];
		c[2] = f[0] * up[1] - f[1] * up[0];
		ok_r = unit_vec(c, r);
		u[0] = round_q(r[1] * f[2] - r[2] * f[1]);
		u[1] = round_q(r[2] * f[0] - r[0] * f[2]);
		u[2] = round_q(r[0] * f[1] - r[1] * f[0]);
		for (int k = 0; k < 3; k++) begin
			if (k == 0) rw = r;
			else if (k == 1) rw = u;
			else rw = f;
			dot = rw[0] * eye[0] + rw[1] * eye[1] + rw[2] * eye[2];
			e.row = k == 0 ? ROW_R : (k == 1 ? ROW_U : ROW_F);
			e.c0 = 32'(clamp32(rw[0]));
			e.c1 = 32'(clamp32(rw[1]));
			e.c2 = 32'(clamp32(rw[2]));
			e.c3 = 32'(clamp32(-round_q(dot)));
			e.last = k == 2;
			e.degen = !(ok_f && ok_r);
			expected_rows.push_back(e);
		end
	endtask

	function automatic logic [287:0] pack_camera(input logic [31:0] v[9]);
		logic [287:0] w;
		for (int i = 0; i < 9; i++) w[32*i +: 32] = v[i];
		return w;
	endfunction

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'($signed($urandom_range(0, 2000)) - 1000) << FRAC_BITS;
			2: return $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
			3: return 32'($signed($urandom_range(0, 64)) - 32);
			default: return 32'($signed($urandom_range(0, 40000)) - 20000) << 8;
		endcase
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		logic [31:0] v[9];
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		v = '{0, 0, 32'h50000, 0, 0, 0, 0, 32'h10000, 0};
		pending_words.push_back(pack_camera(v));
		v = '{32'h10000, 32'h20000, 32'h30000, 32'h10000, 32'h20000, 32'h30000,
			0, 32'h10000, 0};
		pending_words.push_back(pack_camera(v));
		v = '{0, 0, 0, 0, 32'h40000, 0, 0, 32'h10000, 0};
		pending_words.push_back(pack_camera(v));
		v = '{0, 0, 0, 32'h10000, 32'h10000, 0, 0, 0, 0};
		pending_words.push_back(pack_camera(v));
		v = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000,
			32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF};
		pending_words.push_back(pack_camera(v));
		v = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
			32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000};
		pending_words.push_back(pack_camera(v));
		v = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 0, 0, 0, 1, 0, 0};
		pending_words.push_back(pack_camera(v));
		v = '{32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0, 32'h55555555,
			32'hAAAAAAAA, 32'h1, 32'hFFFFFFFF, 32'h7FFF0000};
		pending_words.push_back(pack_camera(v));
		for (int n = 0; n < 262; n++) begin
			for (int i = 0; i < 9; i++) v[i] = rand_coord();
			case ($urandom_range(0, 15))
				0: for (int i = 0; i < 3; i++) v[3+i] = v[i];
				1: for (int i = 0; i < 3; i++) v[6+i] = 0;
				2: for (int i = 0; i < 3; i++) v[6+i] = v[3+i] - v[i];
				default: ;
			endcase
			pending_words.push_back(pack_camera(v));
			if (n == 120) begin
				wait (pending_words.size() == 0);
				hold_send = 1;
				wait (expected_rows.size() == 0);
				hold_send = 0;
			end
		end
		wait (pending_words.size() == 0);
		stimulus_done = 1;
	end

	initial begin
		errors = 0; rows_seen = 0; idle_cycles = 0; degen_seen = 0;
		send_gap = 0; recv_gap = 0; stimulus_done = 0; hold_send = 0;
		s_tvalid = 0; s_tdata = '0; m_tready = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_view_rows(s_tdata);
				void'(pending_words.pop_front());
				send_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4);
			end
			if (s_tvalid && !s_tready) begin
			end else if (send_gap > 0 || hold_send || pending_words.size() == 0
					|| (s_tvalid && s_tready && pending_words.size() == 0)) begin
				s_tvalid <= 0;
				if (send_gap > 0) send_gap--;
			end else begin
				s_tvalid <= 1;
				s_tdata  <= pending_words[0];
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		row_word_t e;
		if (!arst_n) begin
			m_tready <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				rows_seen++;
				if (m_tuser) degen_seen++;
				if (expected_rows.size() == 0) begin
					errors++;
					$display("%0t unexpected row: got %h", $time, m_tdata);
				end else begin
					e = expected_rows.pop_front();
					if ({m_tdata[129:0], m_tlast, m_tuser} !==
							{e.c3, e.c2, e.c1, e.c0, e.row, e.last, e.degen}) begin
						errors++;
						$display("%0t row mismatch: expected idx %0d %h %h %h %h last %b dg %b",
							$time, e.row, e.c0, e.c1, e.c2, e.c3, e.last, e.degen);
						$display("%0t                actual idx %0d %h %h %h %h last %b dg %b",
							$time, m_tdata[1:0], m_tdata[33:2], m_tdata[65:34],
							m_tdata[97:66], m_tdata[129:98], m_tlast, m_tuser);
					end
				end
				recv_gap = $urandom_range(0, 1) ? 0 : $urandom_range(0, 4);
			end
			if (recv_gap > 0) begin
				m_tready <= 0;
				recv_gap--;
			end else begin
				m_tready <= 1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		wait (stimulus_done);
		wait (expected_rows.size() == 0);
		repeat (300) @(posedge clk);
		$display("Covered %0d rows from 270 camera setups, %0d rows flagged degenerate.",
			rows_seen, degen_seen);
		if (errors == 0 && expected_rows.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

[files.f]
rtl/lav_pkg.sv
rtl/lav_norm.sv
rtl/look_at_view_matrix.sv
tb/tb_look_at_view_matrix.sv
